FILE: hw/rtl/clp_pkg.sv
// ---------------------------------------------------------------------------
// clp_pkg
// Shared types and constants for the cursor linked list pool.
// ---------------------------------------------------------------------------
package clp_pkg;

	// pool geometry, fixed by the 6-bit node index fields
	localparam int IDX_W        = 6;
	localparam int POOL_ENTRIES = 1 << IDX_W;
	localparam int VAL_W        = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [1:0] {
		OP_NEW    = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// request item
	typedef struct packed {
		op_t                     op;
		idx_t                    list_head;
		idx_t                    position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// result item
	typedef struct packed {
		idx_t    result_index;
		status_t status;
	} rsp_t;

	// write port of the link memory
	typedef struct packed {
		logic we;
		idx_t addr;
		idx_t data;
	} link_wr_t;

	// write port of the value memory
	typedef struct packed {
		logic we;
		idx_t addr;
		val_t data;
	} val_wr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TAKE,
		S_POP,
		S_CLR,
		S_INS_RD,
		S_INS_LNK,
		S_INS_POS,
		S_HOP,
		S_CMP,
		S_DEL_RD,
		S_DEL_LNK,
		S_DEL_FREE
	} state_t;

endpackage

FILE: hw/rtl/clp_link_mem.sv
// ---------------------------------------------------------------------------
// clp_link_mem
// Node link memory, one write and one registered read per cycle. Entries not
// yet written since reset read as their reset link, the next node index.
// ---------------------------------------------------------------------------
module clp_link_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  clp_pkg::idx_t     raddr,
	output clp_pkg::idx_t     rdata,
	input  clp_pkg::link_wr_t wr
);
	import clp_pkg::*;

	idx_t                    mem_q [POOL_ENTRIES];
	logic [POOL_ENTRIES-1:0] vld_q;
	idx_t                    rd_q;
	idx_t                    dflt_q;
	logic                    rd_vld_q;

	// per-entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	// array write
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read with the reset link alongside
	always_ff @(posedge clk) begin
		rd_q   <= mem_q[raddr];
		dflt_q <= (raddr == idx_t'(POOL_ENTRIES - 1)) ? '0 : raddr + idx_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : dflt_q;

endmodule

FILE: hw/rtl/clp_value_mem.sv
// ---------------------------------------------------------------------------
// clp_value_mem
// Node value memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module clp_value_mem (
	input  logic             clk,
	input  clp_pkg::idx_t    raddr,
	output clp_pkg::val_t    rdata,
	input  clp_pkg::val_wr_t wr
);
	import clp_pkg::*;

	val_t mem_q [POOL_ENTRIES];
	val_t rd_q;

	// array write and registered read
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

FILE: hw/rtl/clp_ctrl.sv
// ---------------------------------------------------------------------------
// clp_ctrl
// Request sequencer: free list pops and pushes, list walks with one shared
// value compare per step, and the result register.
// ---------------------------------------------------------------------------
module clp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  clp_pkg::req_t     req,
	output logic              busy,
	output logic              done,
	output clp_pkg::rsp_t     rsp,
	output clp_pkg::idx_t     l_raddr,
	input  clp_pkg::idx_t     l_rdata,
	output clp_pkg::link_wr_t l_wr,
	output clp_pkg::idx_t     v_raddr,
	input  clp_pkg::val_t     v_rdata,
	output clp_pkg::val_wr_t  v_wr
);
	import clp_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	idx_t   pos_q;
	val_t   val_q;
	idx_t   node_q;
	idx_t   prev_q;
	idx_t   cnt_q;
	logic   done_q;
	rsp_t   rsp_q;

	logic    accept;
	logic    match;
	logic    last;
	logic    cont;
	logic    fin;
	idx_t    fin_idx;
	status_t fin_st;

	assign accept = start && (state_q == S_IDLE);
	// shared compare of the node value against the request value
	assign match  = (v_rdata == val_q);
	assign last   = (cnt_q == idx_t'(POOL_ENTRIES - 1));
	assign cont   = !match && !last && (l_rdata != '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.op == OP_NEW || req.op == OP_INSERT) begin
						state_d = S_TAKE;
					end else begin
						state_d = S_HOP;
					end
				end
			end
			S_TAKE:     state_d = (l_rdata == '0) ? S_IDLE : S_POP;
			S_POP:      state_d = (op_q == OP_NEW) ? S_CLR : S_INS_RD;
			S_CLR:      state_d = S_IDLE;
			S_INS_RD:   state_d = S_INS_LNK;
			S_INS_LNK:  state_d = S_INS_POS;
			S_INS_POS:  state_d = S_IDLE;
			S_HOP:      state_d = (l_rdata == '0) ? S_IDLE : S_CMP;
			S_CMP: begin
				if (match) begin
					state_d = (op_q == OP_FIND) ? S_IDLE : S_DEL_RD;
				end else if (cont) begin
					state_d = S_CMP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DEL_RD:   state_d = S_DEL_LNK;
			S_DEL_LNK:  state_d = S_DEL_FREE;
			S_DEL_FREE: state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls and finish
	always_comb begin
		l_raddr = '0;
		v_raddr = '0;
		l_wr    = '0;
		v_wr    = '0;
		fin     = 1'b0;
		fin_idx = '0;
		fin_st  = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (req.op == OP_DELETE || req.op == OP_FIND) begin
					l_raddr = req.list_head;
				end
			end
			S_TAKE: begin
				l_raddr = l_rdata;
				if (l_rdata == '0) begin
					fin    = 1'b1;
					fin_st = ST_FULL;
				end
			end
			S_POP: begin
				l_wr = '{we: 1'b1, addr: '0, data: l_rdata};
				if (op_q == OP_INSERT) begin
					v_wr = '{we: 1'b1, addr: node_q, data: val_q};
				end
			end
			S_CLR: begin
				l_wr    = '{we: 1'b1, addr: node_q, data: '0};
				fin     = 1'b1;
				fin_idx = node_q;
			end
			S_INS_RD: begin
				l_raddr = pos_q;
			end
			S_INS_LNK: begin
				l_wr = '{we: 1'b1, addr: node_q, data: l_rdata};
			end
			S_INS_POS: begin
				l_wr    = '{we: 1'b1, addr: pos_q, data: node_q};
				fin     = 1'b1;
				fin_idx = node_q;
			end
			S_HOP: begin
				l_raddr = l_rdata;
				v_raddr = l_rdata;
				if (l_rdata == '0) begin
					fin    = 1'b1;
					fin_st = ST_MISSING;
				end
			end
			S_CMP: begin
				if (match) begin
					if (op_q == OP_FIND) begin
						fin     = 1'b1;
						fin_idx = node_q;
					end else begin
						// unlink the matched node from its predecessor
						l_wr = '{we: 1'b1, addr: prev_q, data: l_rdata};
					end
				end else if (cont) begin
					l_raddr = l_rdata;
					v_raddr = l_rdata;
				end else begin
					fin    = 1'b1;
					fin_st = ST_MISSING;
				end
			end
			S_DEL_RD: begin
				l_raddr = '0;
			end
			S_DEL_LNK: begin
				l_wr = '{we: 1'b1, addr: node_q, data: l_rdata};
			end
			S_DEL_FREE: begin
				l_wr    = '{we: 1'b1, addr: '0, data: node_q};
				fin     = 1'b1;
				fin_idx = node_q;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	// request fields and walk cursor
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			pos_q  <= req.position;
			val_q  <= val_t'(req.value);
			prev_q <= req.list_head;
			cnt_q  <= '0;
		end
		if (state_q == S_TAKE || state_q == S_HOP) begin
			node_q <= l_rdata;
		end
		if (state_q == S_CMP && cont) begin
			prev_q <= node_q;
			node_q <= l_rdata;
			cnt_q  <= cnt_q + idx_t'(1);
		end
		if (fin) begin
			rsp_q <= '{result_index: fin_idx, status: fin_st};
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hw/rtl/cursor_linked_list_pool.sv
// ---------------------------------------------------------------------------
// cursor_linked_list_pool
// Pool of 64 nodes holding singly linked lists by index, node 0 heading the
// free list.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// shows on rsp for exactly one cycle with done high, and must be captured
// then since there is no way to hold it. busy drops in the same cycle done
// rises, so the next item may be started while the result is shown. New
// list and insert are paced by the link memory's one read and one write
// port (up to three reads and three writes); with the pool empty either one
// answers straight from the read of the free list head. Find and delete walk
// the list, the walk reading one node's link and value per cycle and feeding
// the one value comparator, up to 64 nodes; a delete that hits then unlinks
// the node and returns it to the free list. A missing value or an empty pool
// answers with index 0. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module cursor_linked_list_pool (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  clp_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output clp_pkg::rsp_t rsp
);
	import clp_pkg::*;

	idx_t     l_raddr;
	idx_t     l_rdata;
	link_wr_t l_wr;
	idx_t     v_raddr;
	val_t     v_rdata;
	val_wr_t  v_wr;

	// sequencer
	clp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.l_raddr (l_raddr),
		.l_rdata (l_rdata),
		.l_wr    (l_wr),
		.v_raddr (v_raddr),
		.v_rdata (v_rdata),
		.v_wr    (v_wr)
	);

	// node links
	clp_link_mem u_link_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (l_raddr),
		.rdata  (l_rdata),
		.wr     (l_wr)
	);

	// node values
	clp_value_mem u_value_mem (
		.clk   (clk),
		.raddr (v_raddr),
		.rdata (v_rdata),
		.wr    (v_wr)
	);

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// the block goes idle only together with its result
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// one result per item, never in two adjacent cycles
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a node index comes back exactly when the request succeeded
	a_index_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.status == ST_OK) == (rsp.result_index != '0)))
		else $error("result index disagrees with status");

endmodule
